@@ hdl/brlt_pkg.sv @@
// Shared types and constants for the box region lookup table.
// Holds the command codes, field widths and the control/status structs.
// No dependencies; compile first.
`timescale 1ns / 1ps

package brlt_pkg;

    // Widths of the item fields on the channels
    localparam int CMD_W         = 2;
    localparam int COORD_FIELD_W = 16;
    localparam int INDEX_FIELD_W = 6;
    localparam int COUNT_FIELD_W = 7;

    // Command codes carried by an input item
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;    // item accepted: add, clear, no command or capture lookup point
        logic scan;    // lookup scan in progress
        logic finish;  // lookup resolved: capture the result
    } t_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic hit;        // entry under compare contains the point
        logic exhausted;  // every stored entry compared, no hit
    } t_stat;

endpackage

@@ hdl/brlt_intf.sv @@
// Channel interfaces for the box region lookup table.
// Request carries a command and two corners; response carries the result.
// Depends on brlt_pkg.
`timescale 1ns / 1ps

interface brlt_req_if;
    import brlt_pkg::*;

    logic                            valid;
    logic                            ready;
    logic [CMD_W-1:0]                command;
    logic signed [COORD_FIELD_W-1:0] ax;
    logic signed [COORD_FIELD_W-1:0] ay;
    logic signed [COORD_FIELD_W-1:0] az;
    logic signed [COORD_FIELD_W-1:0] bx;
    logic signed [COORD_FIELD_W-1:0] by;
    logic signed [COORD_FIELD_W-1:0] bz;

    modport source (output valid, command, ax, ay, az, bx, by, bz, input ready);
    modport sink   (input valid, command, ax, ay, az, bx, by, bz, output ready);
endinterface

interface brlt_rsp_if;
    import brlt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     found;
    logic [INDEX_FIELD_W-1:0] box_index;
    logic                     table_full;
    logic [COUNT_FIELD_W-1:0] box_count;

    modport source (output valid, found, box_index, table_full, box_count, input ready);
    modport sink   (input valid, found, box_index, table_full, box_count, output ready);
endinterface

@@ hdl/brlt_ctrl.sv @@
// Controller for the box region lookup table: sequences the lookup scan
// and owns the handshakes of both channels. Depends on brlt_pkg.
`timescale 1ns / 1ps

module brlt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  brlt_pkg::t_cmd  i_cmd,
    input  logic            i_out_ready,
    input  brlt_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output brlt_pkg::t_ctl  o_ctl
);
    import brlt_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state;
    logic   r_out_vld;
    logic   w_accept;
    logic   w_finish;

    // Take an item only when idle and the result register is free or emptying
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_vld || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_finish    = (r_state == S_SCAN) && (i_stat.hit || i_stat.exhausted);
    assign o_out_valid = r_out_vld;

    // Commands to the datapath
    always_comb begin
        o_ctl.exec   = w_accept;
        o_ctl.scan   = (r_state == S_SCAN);
        o_ctl.finish = w_finish;
    end

    // State and result-valid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_cmd == CMD_LOOKUP)) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_finish) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase

            if ((w_accept && (i_cmd != CMD_LOOKUP)) || w_finish) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/brlt_dpath.sv @@
// Datapath for the box region lookup table: box memory, count, scan
// address, containment compare and result register. Depends on brlt_pkg.
`timescale 1ns / 1ps

module brlt_dpath #(
    parameter int MAX_BOXES   = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  brlt_pkg::t_ctl                            i_ctl,
    input  brlt_pkg::t_cmd                            i_cmd,
    input  logic signed [brlt_pkg::COORD_FIELD_W-1:0] i_ax,
    input  logic signed [brlt_pkg::COORD_FIELD_W-1:0] i_ay,
    input  logic signed [brlt_pkg::COORD_FIELD_W-1:0] i_az,
    input  logic signed [brlt_pkg::COORD_FIELD_W-1:0] i_bx,
    input  logic signed [brlt_pkg::COORD_FIELD_W-1:0] i_by,
    input  logic signed [brlt_pkg::COORD_FIELD_W-1:0] i_bz,
    output brlt_pkg::t_stat                           o_stat,
    output logic                                      o_found,
    output logic [brlt_pkg::INDEX_FIELD_W-1:0]        o_box_index,
    output logic                                      o_table_full,
    output logic [brlt_pkg::COUNT_FIELD_W-1:0]        o_box_count
);
    import brlt_pkg::*;

    localparam int CNT_W   = $clog2(MAX_BOXES + 1);
    localparam int IDX_W   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int ENTRY_W = 6 * COORD_WIDTH;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_BOXES);

    // Low COORD_WIDTH bits of a field, zero-filled above the field
    function automatic logic signed [COORD_WIDTH-1:0] to_coord(
        input logic [COORD_FIELD_W-1:0] f
    );
        return COORD_WIDTH'(f);
    endfunction

    // Entry holds lo and hi per axis, lo in the lower bits, axis 0 lowest
    logic [ENTRY_W-1:0]            r_mem [MAX_BOXES];
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              r_addr;
    logic                          r_rd_vld;
    logic [ENTRY_W-1:0]            r_rd_data;
    logic [IDX_W-1:0]              r_rd_idx;
    logic signed [COORD_WIDTH-1:0] r_point [3];

    logic                          r_found;
    logic [IDX_W-1:0]              r_res_idx;
    logic                          r_full;
    logic [CNT_W-1:0]              r_res_count;

    logic signed [COORD_WIDTH-1:0] w_a [3];
    logic signed [COORD_WIDTH-1:0] w_b [3];
    logic [ENTRY_W-1:0]            w_entry;
    logic                          w_full;
    logic                          w_add;
    logic                          w_more;
    logic                          w_issue;
    logic                          w_inside;

    assign w_a[0] = to_coord($unsigned(i_ax));
    assign w_a[1] = to_coord($unsigned(i_ay));
    assign w_a[2] = to_coord($unsigned(i_az));
    assign w_b[0] = to_coord($unsigned(i_bx));
    assign w_b[1] = to_coord($unsigned(i_by));
    assign w_b[2] = to_coord($unsigned(i_bz));

    // Order each axis at insert so the scan compares against lo/hi directly
    always_comb begin
        w_entry = '0;
        for (int k = 0; k < 3; k++) begin
            if (w_a[k] < w_b[k]) begin
                w_entry[2*k*COORD_WIDTH +: COORD_WIDTH]     = w_a[k];
                w_entry[(2*k+1)*COORD_WIDTH +: COORD_WIDTH] = w_b[k];
            end else begin
                w_entry[2*k*COORD_WIDTH +: COORD_WIDTH]     = w_b[k];
                w_entry[(2*k+1)*COORD_WIDTH +: COORD_WIDTH] = w_a[k];
            end
        end
    end

    assign w_full  = (r_count == FULL_CNT);
    assign w_add   = i_ctl.exec && (i_cmd == CMD_ADD) && !w_full;
    assign w_more  = (r_addr < r_count);
    assign w_issue = i_ctl.scan && w_more;

    // Containment test on the entry read last cycle, faces inclusive
    always_comb begin
        logic signed [COORD_WIDTH-1:0] v_lo;
        logic signed [COORD_WIDTH-1:0] v_hi;
        w_inside = 1'b1;
        for (int k = 0; k < 3; k++) begin
            v_lo = $signed(r_rd_data[2*k*COORD_WIDTH +: COORD_WIDTH]);
            v_hi = $signed(r_rd_data[(2*k+1)*COORD_WIDTH +: COORD_WIDTH]);
            if ((r_point[k] < v_lo) || (r_point[k] > v_hi)) begin
                w_inside = 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.hit       = r_rd_vld && w_inside;
        o_stat.exhausted = !w_more && !r_rd_vld;
    end

    // Count, scan address and read-valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.exec) begin
                unique case (i_cmd)
                    CMD_ADD: begin
                        if (!w_full) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    CMD_CLEAR:  r_count <= '0;
                    CMD_LOOKUP: ;
                    CMD_NONE:   ;
                endcase
                r_addr   <= '0;
                r_rd_vld <= 1'b0;
            end else begin
                if (w_issue) begin
                    r_addr <= r_addr + 1'b1;
                end
                r_rd_vld <= w_issue;
            end
        end
    end

    // Box memory write port
    always_ff @(posedge i_clk) begin
        if (w_add) begin
            r_mem[r_count[IDX_W-1:0]] <= w_entry;
        end
    end

    // Box memory read port, one entry per scan cycle
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_data <= r_mem[r_addr[IDX_W-1:0]];
            r_rd_idx  <= r_addr[IDX_W-1:0];
        end
    end

    // Lookup point
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_point <= w_a;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_found     <= 1'b0;
            r_res_idx   <= '0;
            r_full      <= 1'b0;
            r_res_count <= r_count;
            unique case (i_cmd)
                CMD_ADD: begin
                    if (w_full) begin
                        r_full <= 1'b1;
                    end else begin
                        r_res_idx   <= r_count[IDX_W-1:0];
                        r_res_count <= r_count + 1'b1;
                    end
                end
                CMD_CLEAR:  r_res_count <= '0;
                CMD_LOOKUP: ;
                CMD_NONE:   ;
            endcase
        end else if (i_ctl.finish) begin
            r_found     <= o_stat.hit;
            r_res_idx   <= o_stat.hit ? r_rd_idx : '0;
            r_full      <= 1'b0;
            r_res_count <= r_count;
        end
    end

    assign o_found      = r_found;
    assign o_box_index  = INDEX_FIELD_W'(r_res_idx);
    assign o_table_full = r_full;
    assign o_box_count  = COUNT_FIELD_W'(r_res_count);

endmodule

@@ hdl/box_region_lookup_table.sv @@
// Top level of the box region lookup table: controller plus datapath.
// Depends on brlt_pkg, brlt_intf, brlt_ctrl and brlt_dpath.
//
//   channel  dir  handshake        item contents
//   i_req    in   valid / ready    command, ax ay az, bx by bz
//   o_rsp    out  valid / ready    found, box_index, table_full, box_count
//
// Add, clear and the unused command give their result in the cycle after the item.
// A lookup scans stored boxes one per cycle through the single memory read
// port, in address order, and answers with the first box that contains the
// point, or with a miss once every stored box has been compared.
// Synchronous active-low reset empties the table; box contents are not cleared.
// One item at a time; a pending result held by o_rsp.ready stalls the next item.
`timescale 1ns / 1ps

module box_region_lookup_table #(
    parameter int MAX_BOXES   = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    brlt_req_if.sink   i_req,
    brlt_rsp_if.source o_rsp
);
    import brlt_pkg::*;

    t_ctl  w_ctl;
    t_stat w_stat;
    t_cmd  w_cmd;

    assign w_cmd = t_cmd'(i_req.command);

    brlt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_cmd       (w_cmd),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_ctl       (w_ctl)
    );

    brlt_dpath #(
        .MAX_BOXES   (MAX_BOXES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_cmd        (w_cmd),
        .i_ax         (i_req.ax),
        .i_ay         (i_req.ay),
        .i_az         (i_req.az),
        .i_bx         (i_req.bx),
        .i_by         (i_req.by),
        .i_bz         (i_req.bz),
        .o_stat       (w_stat),
        .o_found      (o_rsp.found),
        .o_box_index  (o_rsp.box_index),
        .o_table_full (o_rsp.table_full),
        .o_box_count  (o_rsp.box_count)
    );

    // A lookup never answers in the cycle right after it is taken
    a_lookup_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (w_cmd == CMD_LOOKUP)) |=> !o_rsp.valid)
        else $error("lookup result came without a scan");

    // Every other command answers in the next cycle
    a_direct_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (w_cmd != CMD_LOOKUP)) |=> o_rsp.valid)
        else $error("add/clear result missing");

    // No new item is taken while a scan runs
    a_scan_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.scan |-> !i_req.ready)
        else $error("item accepted during scan");

    // A rejected add never reports a hit
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.table_full) |-> !o_rsp.found)
        else $error("table_full together with found");

endmodule
